### sv/srsw_pkg.sv
// Shared constants, codes and helpers for the selective-repeat send window.
// Used by selective_repeat_send_window, srsw_checker and tb_top; no dependencies of its own.
`timescale 1ns / 1ps

package srsw_pkg;

  // Built window depth and largest chunk length
  localparam int WINDOW  = 16;
  localparam int MAX_LEN = 1024;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int LEN_W   = 11;
  localparam int SEQ_W   = 32;
  localparam int WIN_W   = 7;
  localparam int KIND_W  = 2;
  localparam int FREED_W = 7;

  // Slot index, slot count and wrap-sum widths
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = IDX_W + 1;

  // One stored slot: ack flag over byte length
  localparam int ENTRY_W = LEN_W + 1;

  // Stream payload widths, rounded up to whole bytes
  localparam int S_TDATA_W = ((LEN_W + SEQ_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((SEQ_W + LEN_W + FREED_W + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TX    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SLID  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

  // Physical slot of logical offset off past the ring head
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                 input logic [PTR_W-1:0] off);
    logic [PTR_W-1:0] sum;
    sum = {1'b0, head} + off;
    if (sum >= PTR_W'(WINDOW)) begin
      sum = sum - PTR_W'(WINDOW);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### sv/selective_repeat_send_window.sv
// Selective-repeat send window: slot ring in one RAM, sequencer and output register.
// Depends on srsw_pkg and srsw_ram.
`timescale 1ns / 1ps

// Usage
//   s_axis carries commands: tuser selects load, ack or timeout; tdata holds
//   the chunk length and the ack sequence. m_axis carries results: tuser is
//   the result kind, tlast marks the final result of a command.
//   cfg_* writes the number of slots in use; write it only while idle.
// Timing
//   One command at a time. The slot walk reads one slot of the ring RAM per
//   cycle; a timeout walk pauses while the output register is full.
//   A result waits in the output register while the next command is taken.
// Reset
//   Clears base and next sequence, the ring head and per-slot valid flags, so
//   every slot reads as empty and unacked; no clearing pass is needed.
// Stall
//   A stalled m_axis holds its item; a timeout walk pauses until the output
//   register frees, other commands wait in their final result cycle.
module selective_repeat_send_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [srsw_pkg::S_TDATA_W-1:0] s_axis_tdata,  // chunk_len, ack_seq, zero pad
  input  logic [srsw_pkg::CMD_W-1:0]     s_axis_tuser,  // cmd
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [srsw_pkg::M_TDATA_W-1:0] m_axis_tdata,  // tx_seq, tx_len, freed_slots, zero pad
  output logic [srsw_pkg::KIND_W-1:0]    m_axis_tuser,  // kind
  output logic                           m_axis_tlast,
  // Window size register
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srsw_pkg::WIN_W-1:0]     cfg_data_i
);

  localparam int IDX_W   = srsw_pkg::IDX_W;
  localparam int CNT_W   = srsw_pkg::CNT_W;
  localparam int PTR_W   = srsw_pkg::PTR_W;
  localparam int LEN_W   = srsw_pkg::LEN_W;
  localparam int SEQ_W   = srsw_pkg::SEQ_W;
  localparam int WIN_W   = srsw_pkg::WIN_W;
  localparam int KIND_W  = srsw_pkg::KIND_W;
  localparam int FREED_W = srsw_pkg::FREED_W;
  localparam int ENTRY_W = srsw_pkg::ENTRY_W;
  localparam int WINDOW  = srsw_pkg::WINDOW;
  localparam int M_PAD_W = srsw_pkg::M_TDATA_W - SEQ_W - LEN_W - FREED_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACK,
    ST_SLIDE,
    ST_TIMEOUT,
    ST_RES
  } state_e;

  // Registers
  state_e             state_q, state_d;
  logic [WIN_W-1:0]   cfg_q, cfg_d;
  logic [SEQ_W-1:0]   base_q, base_d;
  logic [SEQ_W-1:0]   next_q, next_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [CNT_W-1:0]   freed_q, freed_d;
  logic [LEN_W-1:0]   ld_len_q, ld_len_d;
  logic               pend_q, pend_d;
  logic [KIND_W-1:0]  res_kind_q, res_kind_d;
  logic [SEQ_W-1:0]   res_seq_q, res_seq_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;
  logic [CNT_W-1:0]   res_freed_q, res_freed_d;
  logic               out_vld_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic [SEQ_W-1:0]   out_seq_q;
  logic [LEN_W-1:0]   out_len_q;
  logic [FREED_W-1:0] out_freed_q;
  logic               out_last_q;
  logic [WINDOW-1:0]  vld_q;
  logic               rdv_q;

  // RAM ports
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Datapath
  logic               in_acc, out_free, push, push_last;
  logic [CNT_W-1:0]   w_cur;
  logic [LEN_W-1:0]   in_len, in_len_sat;
  logic [SEQ_W-1:0]   in_d, in_outst;
  logic               in_ack_ok;
  logic [LEN_W-1:0]   rd_len;
  logic               rd_ack;
  logic               more;
  logic [CNT_W-1:0]   i_nx, freed_fin;
  logic [SEQ_W-1:0]   slot_seq;

  srsw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshakes
  assign in_acc        = s_axis_tvalid && (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Slots in use, clamped to 1..WINDOW
  always_comb begin
    if (cfg_q == '0) begin
      w_cur = CNT_W'(1);
    end else if (cfg_q > WIN_W'(WINDOW)) begin
      w_cur = CNT_W'(WINDOW);
    end else begin
      w_cur = CNT_W'(cfg_q);
    end
  end

  // Command decode helpers
  assign in_len     = s_axis_tdata[LEN_W-1:0];
  assign in_len_sat = (in_len > LEN_W'(srsw_pkg::MAX_LEN)) ?
                      LEN_W'(srsw_pkg::MAX_LEN) : in_len;
  assign in_d       = s_axis_tdata[LEN_W +: SEQ_W] - base_q;
  assign in_outst   = next_q - base_q;
  assign in_ack_ok  = (in_d < in_outst) && (in_d < SEQ_W'(WINDOW));

  // Slot read back; never-written slots read as empty and unacked
  assign rd_len   = rdv_q ? ram_rdata[LEN_W-1:0] : '0;
  assign rd_ack   = rdv_q && ram_rdata[LEN_W];
  assign i_nx     = i_q + CNT_W'(1);
  assign more     = (i_nx < w_cur);
  assign slot_seq = base_q + SEQ_W'(i_q);

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    base_d      = base_q;
    next_d      = next_q;
    head_d      = head_q;
    i_d         = i_q;
    freed_d     = freed_q;
    ld_len_d    = ld_len_q;
    pend_d      = pend_q;
    res_kind_d  = res_kind_q;
    res_seq_d   = res_seq_q;
    res_len_d   = res_len_q;
    res_freed_d = res_freed_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    push        = 1'b0;
    push_last   = 1'b0;
    freed_fin   = freed_q;

    if (cfg_valid_i) begin
      cfg_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            srsw_pkg::CMD_LOAD: begin
              if (in_len != '0) begin
                ld_len_d  = in_len_sat;
                i_d       = '0;
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = ST_LOAD;
              end
            end
            srsw_pkg::CMD_ACK: begin
              if (in_ack_ok) begin
                ram_re    = 1'b1;
                ram_raddr = srsw_pkg::slot_addr(head_q, PTR_W'(in_d[IDX_W-1:0]));
                i_d       = CNT_W'(in_d[IDX_W-1:0]);
                freed_d   = '0;
                state_d   = (in_d == '0) ? ST_SLIDE : ST_ACK;
              end
            end
            srsw_pkg::CMD_TIMEOUT: begin
              i_d       = '0;
              pend_d    = 1'b0;
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = ST_TIMEOUT;
            end
            default: begin
            end
          endcase
        end
      end

      // Set the ack flag of an outstanding slot past base
      ST_ACK: begin
        ram_we    = 1'b1;
        ram_waddr = srsw_pkg::slot_addr(head_q, PTR_W'(i_q));
        ram_wdata = {1'b1, rd_len};
        state_d   = ST_IDLE;
      end

      // Count and clear the run of acked slots; base slot counts as acked
      ST_SLIDE: begin
        if (rd_ack || (i_q == '0)) begin
          ram_we    = 1'b1;
          ram_waddr = srsw_pkg::slot_addr(head_q, PTR_W'(i_q));
          ram_wdata = '0;
          freed_fin = freed_q + CNT_W'(1);
          freed_d   = freed_fin;
        end
        if ((rd_ack || (i_q == '0)) && more) begin
          i_d       = i_nx;
          ram_re    = 1'b1;
          ram_raddr = srsw_pkg::slot_addr(head_q, PTR_W'(i_nx));
        end else begin
          res_kind_d  = srsw_pkg::KIND_SLID;
          res_seq_d   = '0;
          res_len_d   = '0;
          res_freed_d = freed_fin;
          base_d      = base_q + SEQ_W'(freed_fin);
          head_d      = srsw_pkg::slot_addr(head_q, PTR_W'(freed_fin));
          state_d     = ST_RES;
        end
      end

      // Fill the first empty slot in use, or report the window full
      ST_LOAD: begin
        if (rd_len == '0) begin
          ram_we      = 1'b1;
          ram_waddr   = srsw_pkg::slot_addr(head_q, PTR_W'(i_q));
          ram_wdata   = {1'b0, ld_len_q};
          if (slot_seq == next_q) begin
            next_d = next_q + SEQ_W'(1);
          end
          res_kind_d  = srsw_pkg::KIND_TX;
          res_seq_d   = slot_seq;
          res_len_d   = ld_len_q;
          res_freed_d = '0;
          state_d     = ST_RES;
        end else if (more) begin
          i_d       = i_nx;
          ram_re    = 1'b1;
          ram_raddr = srsw_pkg::slot_addr(head_q, PTR_W'(i_nx));
        end else begin
          res_kind_d  = srsw_pkg::KIND_FULL;
          res_seq_d   = '0;
          res_len_d   = '0;
          res_freed_d = '0;
          state_d     = ST_RES;
        end
      end

      // Walk filled slots; one order is held back so the final one gets tlast
      ST_TIMEOUT: begin
        if (rd_len == '0) begin
          if (i_q == '0) begin
            res_kind_d  = srsw_pkg::KIND_EMPTY;
            res_seq_d   = '0;
            res_len_d   = '0;
            res_freed_d = '0;
            state_d     = ST_RES;
          end else begin
            state_d = pend_q ? ST_RES : ST_IDLE;
          end
        end else if (!rd_ack && pend_q && !out_free) begin
          // wait for the output register
        end else begin
          if (!rd_ack) begin
            push        = pend_q;
            res_kind_d  = srsw_pkg::KIND_TX;
            res_seq_d   = slot_seq;
            res_len_d   = rd_len;
            res_freed_d = '0;
            pend_d      = 1'b1;
          end
          if (more) begin
            i_d       = i_nx;
            ram_re    = 1'b1;
            ram_raddr = srsw_pkg::slot_addr(head_q, PTR_W'(i_nx));
          end else begin
            state_d = (pend_q || !rd_ack) ? ST_RES : ST_IDLE;
          end
        end
      end

      // Final result of the command
      ST_RES: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, output register and slot valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= WIN_W'(16);
      base_q      <= '0;
      next_q      <= '0;
      head_q      <= '0;
      i_q         <= '0;
      freed_q     <= '0;
      ld_len_q    <= '0;
      pend_q      <= 1'b0;
      res_kind_q  <= '0;
      res_seq_q   <= '0;
      res_len_q   <= '0;
      res_freed_q <= '0;
      out_vld_q   <= 1'b0;
      out_kind_q  <= '0;
      out_seq_q   <= '0;
      out_len_q   <= '0;
      out_freed_q <= '0;
      out_last_q  <= 1'b0;
      vld_q       <= '0;
      rdv_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      base_q      <= base_d;
      next_q      <= next_d;
      head_q      <= head_d;
      i_q         <= i_d;
      freed_q     <= freed_d;
      ld_len_q    <= ld_len_d;
      pend_q      <= pend_d;
      res_kind_q  <= res_kind_d;
      res_seq_q   <= res_seq_d;
      res_len_q   <= res_len_d;
      res_freed_q <= res_freed_d;
      if (push) begin
        out_vld_q   <= 1'b1;
        out_kind_q  <= res_kind_q;
        out_seq_q   <= res_seq_q;
        out_len_q   <= res_len_q;
        out_freed_q <= FREED_W'(res_freed_q);
        out_last_q  <= push_last;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rdv_q <= vld_q[ram_raddr];
      end
    end
  end

  // Result stream
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_freed_q, out_len_q, out_seq_q};

  // Checks

  // The walk never reads the slot it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ring read and write hit the same slot");

  // The walk index stays inside the slots in use
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_SLIDE || state_q == ST_TIMEOUT)
    |-> (i_q < w_cur))
    else $error("slot walk past the window in use");

  // A result is only loaded when the output register has room
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result overwrote a waiting item");

  // A slide always frees at least the base slot
  a_slide_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == srsw_pkg::KIND_SLID) |-> (m_axis_tdata[SEQ_W +
    LEN_W +: FREED_W] != '0))
    else $error("slide reported with no slot freed");

  // The final result returns the sequencer to idle
  a_res_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RES && out_free) |=> (state_q == ST_IDLE))
    else $error("sequencer stuck after final result");

endmodule

### sv/srsw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module srsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/srsw_checker.sv
// Result checker for the selective-repeat send window: tracks the slot ring,
// predicts each result item and compares it with what leaves m_axis.
// Depends on srsw_pkg.
`timescale 1ns / 1ps

module srsw_checker
  import srsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command stream, watched
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // chunk_len, ack_seq, zero pad
  input  logic [CMD_W-1:0]     s_axis_tuser,   // cmd
  // Result stream, watched
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,   // tx_seq, tx_len, freed_slots, zero pad
  input  logic [KIND_W-1:0]    m_axis_tuser,   // kind
  input  logic                 m_axis_tlast,
  // Window size register, watched
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [WIN_W-1:0]     cfg_data_i,
  // Status for the stimulus side
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output logic [SEQ_W-1:0]     base_seq_o,
  output logic [SEQ_W-1:0]     next_seq_o
);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SEQ_W-1:0]   seq;
    logic [LEN_W-1:0]   len;
    logic [FREED_W-1:0] freed;
    logic               last;
  } window_result_t;

  // Shadow copy of the window
  logic [LEN_W-1:0] slot_len_q   [WINDOW];
  logic             slot_acked_q [WINDOW];
  logic [SEQ_W-1:0] base_seq_q;
  logic [SEQ_W-1:0] next_seq_q;
  logic [WIN_W-1:0] win_reg_q;

  window_result_t expected_orders[$];
  int unsigned    fails;

  // Apply one accepted command to the shadow window, queue its results
  task automatic advance_window(input logic [CMD_W-1:0] cmd,
                                input logic [LEN_W-1:0] len_in,
                                input logic [SEQ_W-1:0] seq_in);
    int             w;
    int             freed;
    int             i;
    bit             placed;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] off;
    logic [SEQ_W-1:0] outst;
    window_result_t r;
    window_result_t burst[$];
    w = int'(win_reg_q);
    if (w < 1) w = 1;
    if (w > WINDOW) w = WINDOW;
    r = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_LOAD: begin
        if (len_in != '0) begin
          len = (len_in > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_in;
          placed = 1'b0;
          r.kind = KIND_FULL;
          for (i = 0; i < w && !placed; i++) begin
            if (slot_len_q[i] == '0) begin
              placed = 1'b1;
              slot_len_q[i]   = len;
              slot_acked_q[i] = 1'b0;
              r.kind = KIND_TX;
              r.seq  = base_seq_q + SEQ_W'(i);
              r.len  = len;
              if (r.seq == next_seq_q) next_seq_q = next_seq_q + 1'b1;
            end
          end
          expected_orders.push_back(r);
        end
      end
      CMD_ACK: begin
        off   = seq_in - base_seq_q;
        outst = next_seq_q - base_seq_q;
        if (off < outst && off < SEQ_W'(WINDOW)) begin
          slot_acked_q[off] = 1'b1;
          if (off == '0) begin
            // count the run of acked slots, then shift the ring down
            freed = 0;
            while (freed < w && slot_acked_q[freed]) freed++;
            for (i = 0; i < WINDOW; i++) begin
              if (i + freed < WINDOW) begin
                slot_len_q[i]   = slot_len_q[i + freed];
                slot_acked_q[i] = slot_acked_q[i + freed];
              end else begin
                slot_len_q[i]   = '0;
                slot_acked_q[i] = 1'b0;
              end
            end
            base_seq_q = base_seq_q + SEQ_W'(freed);
            r.kind  = KIND_SLID;
            r.freed = FREED_W'(freed);
            expected_orders.push_back(r);
          end
        end
      end
      CMD_TIMEOUT: begin
        if (slot_len_q[0] == '0) begin
          r.kind = KIND_EMPTY;
          expected_orders.push_back(r);
        end else begin
          // retransmit filled, unacked slots up to the first hole
          for (i = 0; i < w && slot_len_q[i] != '0; i++) begin
            if (!slot_acked_q[i]) begin
              r.kind = KIND_TX;
              r.seq  = base_seq_q + SEQ_W'(i);
              r.len  = slot_len_q[i];
              burst.push_back(r);
            end
          end
          foreach (burst[k]) begin
            r = burst[k];
            r.last = (k == burst.size() - 1);
            expected_orders.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t got;
    window_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        slot_len_q[i]   = '0;
        slot_acked_q[i] = 1'b0;
      end
      base_seq_q = '0;
      next_seq_q = '0;
      win_reg_q  = WIN_W'(16);
      fails      = 0;
      expected_orders.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      base_seq_o   <= '0;
      next_seq_o   <= '0;
    end else begin
      // compare first so an item accepted now cannot match an earlier result
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = m_axis_tuser;
        got.seq   = m_axis_tdata[SEQ_W-1:0];
        got.len   = m_axis_tdata[SEQ_W+LEN_W-1:SEQ_W];
        got.freed = m_axis_tdata[SEQ_W+LEN_W+FREED_W-1:SEQ_W+LEN_W];
        got.last  = m_axis_tlast;
        if (expected_orders.size() == 0) begin
          fails++;
          $display("%0t: unexpected result item: kind %0d seq %0h len %0d freed %0d last %0b",
                   $time, got.kind, got.seq, got.len, got.freed, got.last);
        end else begin
          exp_r = expected_orders.pop_front();
          if (got !== exp_r) begin
            fails++;
            $display("%0t: mismatch: expected kind %0d seq %0h len %0d freed %0d last %0b",
                     $time, exp_r.kind, exp_r.seq, exp_r.len, exp_r.freed, exp_r.last);
            $display("%0t:           actual   kind %0d seq %0h len %0d freed %0d last %0b",
                     $time, got.kind, got.seq, got.len, got.freed, got.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) win_reg_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        advance_window(s_axis_tuser, s_axis_tdata[LEN_W-1:0],
                       s_axis_tdata[LEN_W+SEQ_W-1:LEN_W]);
      end
      fail_count_o <= fails;
      pending_o    <= expected_orders.size();
      base_seq_o   <= base_seq_q;
      next_seq_o   <= next_seq_q;
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top for selective_repeat_send_window: clock, reset, command
// stimulus, result back-pressure and verdict. Depends on srsw_pkg and srsw_checker.
`timescale 1ns / 1ps

module tb_top;
  import srsw_pkg::*;

  localparam int DRAIN_CYCLES = 2 * WINDOW + 8;  // longest walk plus margin
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 56;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = CMD_LOAD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WIN_W-1:0]     cfg_data = '0;

  int unsigned          fail_count;
  int unsigned          pending;
  logic [SEQ_W-1:0]     win_base;
  logic [SEQ_W-1:0]     win_next;

  int unsigned          src_idle_pct = 0;
  int unsigned          sink_stall_pct = 0;
  int unsigned          hold_reqs = 0;
  int unsigned          hold_done = 0;
  int unsigned          hold_left = 0;
  int unsigned          quiet_cycles = 0;

  logic [WIN_W-1:0]     win_settings [8] = '{7'd64, 7'd3, 7'd127, 7'd0,
                                             7'd16, 7'd1, 7'd1, 7'd8};

  selective_repeat_send_window i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  srsw_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .base_seq_o    (win_base),
    .next_seq_o    (win_next)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result sink: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_done != hold_reqs) begin
      m_axis_tready <= 1'b0;
      hold_done     <= hold_done + 1;
      hold_left     <= HOLD_CYCLES;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: too long without any item moving on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command item and wait for it to be taken
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
                              input logic [SEQ_W-1:0] seq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= S_TDATA_W'({seq, len});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering, wait for every expected result and let the block settle
  task automatic drain_window();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    drain_window();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Mostly loads and acks near the window, some noise
  task automatic random_command();
    int unsigned      pick;
    int unsigned      sub;
    logic [SEQ_W-1:0] outst;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    pick  = $urandom_range(99);
    sub   = $urandom_range(99);
    outst = win_next - win_base;
    seq   = $urandom;
    len   = LEN_W'($urandom_range(0, 2047));
    if (pick < 42) begin
      if (sub < 4)       len = '0;
      else if (sub < 12) len = LEN_W'($urandom_range(MAX_LEN + 1, 2047));
      else if (sub < 20) len = LEN_W'($urandom_range(1, 4));
      else               len = LEN_W'($urandom_range(1, MAX_LEN));
      send_command(CMD_LOAD, len, seq);
    end else if (pick < 80) begin
      if (sub < 55 && outst != '0 && outst <= SEQ_W'(WINDOW))
        seq = win_base + SEQ_W'($urandom_range(0, int'(outst) - 1));
      else if (sub < 75) seq = win_base;
      else if (sub < 88) seq = win_next + SEQ_W'($urandom_range(0, 3));
      send_command(CMD_ACK, len, seq);
    end else if (pick < 95) begin
      send_command(CMD_TIMEOUT, len, seq);
    end else begin
      send_command(CMD_TIMEOUT | CMD_ACK, len, seq);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset window of 16
    send_command(CMD_TIMEOUT, '0, '0);           // empty window
    send_command(CMD_LOAD, '0, '0);              // zero length, ignored
    send_command(CMD_LOAD, 11'd1, '1);
    send_command(CMD_LOAD, 11'd1024, '0);
    send_command(CMD_LOAD, 11'd2047, '0);        // saturates
    send_command(CMD_LOAD, 11'd1025, '0);
    send_command(CMD_ACK, '0, 32'd100);          // not outstanding
    send_command(CMD_ACK, '1, 32'hFFFF_FFFF);    // wraps below base
    send_command(CMD_ACK, '0, 32'd2);            // flag only
    send_command(CMD_TIMEOUT, '0, '0);           // skips the acked slot
    send_command(CMD_ACK, '0, 32'd0);            // slide by one
    send_command(CMD_ACK, '0, 32'd1);            // slide past the acked run
    send_command(CMD_ACK, '0, 32'd1);            // stale
    send_command(CMD_TIMEOUT | CMD_ACK, '1, '1); // unknown command
    send_command(CMD_ACK, '0, 32'd3);            // window empties
    send_command(CMD_TIMEOUT, '0, '0);

    // Directed: a single slot
    write_window(7'd1);
    send_command(CMD_LOAD, 11'd5, '0);
    send_command(CMD_LOAD, 11'd6, '0);           // window full
    send_command(CMD_TIMEOUT, '0, '0);
    send_command(CMD_ACK, '0, 32'd4);

    // Random phases over window settings and idling modes
    win_settings[6] = WIN_W'($urandom_range(1, 64));
    for (int ph = 0; ph < 8; ph++) begin
      write_window(win_settings[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
        1: begin src_idle_pct = 67; sink_stall_pct <= 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct <= 67; end
        default: begin src_idle_pct = 36; sink_stall_pct <= 36; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long sink hold-off while loads keep arriving
        if (ph == 2 && k == 8) hold_reqs <= hold_reqs + 1;
        random_command();
      end
    end

    drain_window();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
